>>> rtl/bit_vector_jaccard_similarity_assert.svh
// Assertion macros for the bit-vector Jaccard similarity block.
// No dependencies; included by the port checker.
`ifndef BIT_VECTOR_JACCARD_SIMILARITY_ASSERT_SVH
`define BIT_VECTOR_JACCARD_SIMILARITY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BVJS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvjs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BVJS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvjs assertion failed");

`endif

>>> rtl/bvjs_pkg.sv
// Shared constants, types and the popcount function of the Jaccard block.
// No dependencies; imported by every module of the block.
package bvjs_pkg;

    localparam int WORD_W            = 64;
    localparam int POP_W             = 7;
    localparam int COUNT_W           = 15;
    localparam int SUM_W             = COUNT_W + 1;
    localparam int PCT_W             = 7;
    localparam int PROD_W            = COUNT_W + PCT_W;
    localparam int PCT_SCALE         = 100;
    localparam int COUNT_MAX         = (1 << COUNT_W) - 1;
    localparam int MAX_WORDS_DEFAULT = 256;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_IDX_W         = $clog2(PCT_W);

    // sim_mode encodings
    localparam logic MODE_XOR = 1'b0;
    localparam logic MODE_AND = 1'b1;

    // Finished totals of one vector pair, handed from front to back.
    typedef struct packed {
        logic [COUNT_W-1:0] sim;
        logic [COUNT_W-1:0] uni;
    } bvjs_entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } bvjs_qstat_t;

    // Population count of one 64-bit word as a six-level adder tree.
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] w);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++) begin
            l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

>>> rtl/bvjs_front.sv
// Front end: accepts word pairs, counts bits and accumulates per-vector totals.
// Depends on bvjs_pkg; feeds bvjs_queue.
module bvjs_front #(
    parameter int MAX_WORDS = bvjs_pkg::MAX_WORDS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [bvjs_pkg::WORD_W-1:0]       word_a,
    input  logic [bvjs_pkg::WORD_W-1:0]       word_b,
    input  logic                              last_word,
    output logic                              q_push,
    output bvjs_pkg::bvjs_entry_t             q_wdata,
    input  bvjs_pkg::bvjs_qstat_t             q_stat
);
    import bvjs_pkg::*;

    localparam longint RawCap   = longint'(MAX_WORDS) * WORD_W;
    localparam int     CountCap = (RawCap > COUNT_MAX) ? COUNT_MAX : int'(RawCap);
    localparam logic [SUM_W-1:0] CapSum = SUM_W'(CountCap);

    logic               mode_reg;
    logic               p1_valid_reg;
    logic               p1_last_reg;
    logic [POP_W-1:0]   p1_sim_pop_reg;
    logic [POP_W-1:0]   p1_uni_pop_reg;
    logic [COUNT_W-1:0] sim_acc_reg, sim_acc_next;
    logic [COUNT_W-1:0] uni_acc_reg, uni_acc_next;
    logic [SUM_W-1:0]   sim_sum, uni_sum;
    logic [COUNT_W-1:0] sim_sat, uni_sat;
    logic [WORD_W-1:0]  comb_word;
    logic               accept;
    logic [QCNT_W:0]    committed;

    assign cfg_ready = 1'b1;

    // A last word in the count stage already owns a queue slot.
    assign committed = {1'b0, q_stat.count} + (QCNT_W+1)'(p1_valid_reg & p1_last_reg);
    assign full      = (committed >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept    = push & ~full;

    assign comb_word = (mode_reg == MODE_AND) ? (word_a & word_b) : (word_a ^ word_b);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg     <= MODE_XOR;
            p1_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            p1_last_reg    <= last_word;
            p1_sim_pop_reg <= popcount64(comb_word);
            p1_uni_pop_reg <= popcount64(word_a | word_b);
        end
    end

    always_comb begin
        sim_sum = SUM_W'(sim_acc_reg) + SUM_W'(p1_sim_pop_reg);
        uni_sum = SUM_W'(uni_acc_reg) + SUM_W'(p1_uni_pop_reg);
        sim_sat = (sim_sum > CapSum) ? CapSum[COUNT_W-1:0] : sim_sum[COUNT_W-1:0];
        uni_sat = (uni_sum > CapSum) ? CapSum[COUNT_W-1:0] : uni_sum[COUNT_W-1:0];

        sim_acc_next = sim_acc_reg;
        uni_acc_next = uni_acc_reg;
        if (p1_valid_reg) begin
            if (p1_last_reg) begin
                sim_acc_next = '0;
                uni_acc_next = '0;
            end else begin
                sim_acc_next = sim_sat;
                uni_acc_next = uni_sat;
            end
        end
    end

    assign q_push      = p1_valid_reg & p1_last_reg;
    assign q_wdata.sim = sim_sat;
    assign q_wdata.uni = uni_sat;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sim_acc_reg <= '0;
            uni_acc_reg <= '0;
        end else begin
            sim_acc_reg <= sim_acc_next;
            uni_acc_reg <= uni_acc_next;
        end
    end

endmodule

>>> rtl/bvjs_queue.sv
// Short queue of finished vector totals between front end and back end.
// Depends on bvjs_pkg.
module bvjs_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  bvjs_pkg::bvjs_entry_t  wr_data,
    input  logic                   rd_en,
    output bvjs_pkg::bvjs_entry_t  rd_data,
    output bvjs_pkg::bvjs_qstat_t  stat
);
    import bvjs_pkg::*;

    bvjs_entry_t       mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

>>> rtl/bvjs_back.sv
// Back end: scales the totals, divides bit by bit and holds the result.
// Depends on bvjs_pkg; drains bvjs_queue.
module bvjs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bvjs_pkg::bvjs_qstat_t         q_stat,
    input  bvjs_pkg::bvjs_entry_t         q_rdata,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [bvjs_pkg::COUNT_W-1:0]  sim_count,
    output logic [bvjs_pkg::COUNT_W-1:0]  union_count,
    output logic [bvjs_pkg::PCT_W-1:0]    jaccard_pct,
    output logic                          empty_union
);
    import bvjs_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_HOLD
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]   s_reg, s_next;
    logic [COUNT_W-1:0]   u_reg, u_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [PCT_W-1:0]     quo_reg, quo_next;
    logic [DIV_IDX_W-1:0] bit_reg, bit_next;
    logic                 res_valid_reg, res_valid_next;
    logic [COUNT_W-1:0]   res_sim_reg, res_sim_next;
    logic [COUNT_W-1:0]   res_uni_reg, res_uni_next;
    logic [PCT_W-1:0]     res_pct_reg, res_pct_next;
    logic                 res_empty_reg, res_empty_next;
    logic [PROD_W-1:0]    trial;
    logic                 u_zero;

    assign trial  = PROD_W'(u_reg) << bit_reg;
    assign u_zero = (u_reg == '0);

    always_comb begin
        state_next     = state_reg;
        s_next         = s_reg;
        u_next         = u_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        res_valid_next = res_valid_reg;
        res_sim_next   = res_sim_reg;
        res_uni_next   = res_uni_reg;
        res_pct_next   = res_pct_reg;
        res_empty_next = res_empty_reg;
        q_pop          = 1'b0;

        if (pop && res_valid_reg) begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    s_next     = q_rdata.sim;
                    u_next     = q_rdata.uni;
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                rem_next   = PROD_W'(s_reg) * PROD_W'(PCT_SCALE);
                quo_next   = '0;
                bit_next   = DIV_IDX_W'(PCT_W - 1);
                state_next = B_DIV;
            end
            B_DIV: begin
                if (rem_reg >= trial) begin
                    rem_next          = rem_reg - trial;
                    quo_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0) begin
                    state_next = B_HOLD;
                end else begin
                    bit_next = bit_reg - DIV_IDX_W'(1);
                end
            end
            B_HOLD: begin
                if (!res_valid_reg || pop) begin
                    res_valid_next = 1'b1;
                    res_sim_next   = s_reg;
                    res_uni_next   = u_reg;
                    res_empty_next = u_zero;
                    if (u_zero) begin
                        res_pct_next = '0;
                    end else if (quo_reg > PCT_W'(PCT_SCALE)) begin
                        res_pct_next = PCT_W'(PCT_SCALE);
                    end else begin
                        res_pct_next = quo_reg;
                    end
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            s_reg         <= '0;
            u_reg         <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            bit_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_sim_reg   <= '0;
            res_uni_reg   <= '0;
            res_pct_reg   <= '0;
            res_empty_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            u_reg         <= u_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            bit_reg       <= bit_next;
            res_valid_reg <= res_valid_next;
            res_sim_reg   <= res_sim_next;
            res_uni_reg   <= res_uni_next;
            res_pct_reg   <= res_pct_next;
            res_empty_reg <= res_empty_next;
        end
    end

    assign empty       = ~res_valid_reg;
    assign sim_count   = res_sim_reg;
    assign union_count = res_uni_reg;
    assign jaccard_pct = res_pct_reg;
    assign empty_union = res_empty_reg;

endmodule

>>> rtl/bit_vector_jaccard_similarity.sv
// Top level of the bit-vector Jaccard similarity block.
// Depends on bvjs_pkg, bvjs_front, bvjs_queue and bvjs_back.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ------------------------------------------------
//   input     push / full             word_a, word_b, last_word
//   result    empty / pop             sim_count, union_count, jaccard_pct, empty_union
//   config    cfg_valid / cfg_ready   cfg_data (sim_mode)
//
// One word pair is taken per cycle while full is low; its bit counts are registered
// in the count stage, then added into the totals. Each finished vector costs the back
// end a pop, a scale by 100, seven divider steps and the output load. Vectors
// shorter than ten words, or a receiver that stops popping, fill the two-entry
// queue and raise full. Reset is asynchronous and active low; it clears both
// totals, the queue and the output register, and sets sim_mode to XOR.
module bit_vector_jaccard_similarity #(
    parameter int MAX_WORDS = bvjs_pkg::MAX_WORDS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel; the write data is sim_mode.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    // Word-pair input, queue style.
    input  logic                          push,
    output logic                          full,
    input  logic [bvjs_pkg::WORD_W-1:0]   word_a,
    input  logic [bvjs_pkg::WORD_W-1:0]   word_b,
    input  logic                          last_word,
    // Result output, queue style.
    output logic                          empty,
    input  logic                          pop,
    output logic [bvjs_pkg::COUNT_W-1:0]  sim_count,
    output logic [bvjs_pkg::COUNT_W-1:0]  union_count,
    output logic [bvjs_pkg::PCT_W-1:0]    jaccard_pct,
    output logic                          empty_union
);
    import bvjs_pkg::*;

    // Totals of a finished vector pair travel through the queue as one
    // transaction; the back end pops it when its divider is free.
    logic        q_push;
    logic        q_pop;
    bvjs_entry_t q_wdata;
    bvjs_entry_t q_rdata;
    bvjs_qstat_t q_stat;

    bvjs_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .word_a    (word_a),
        .word_b    (word_b),
        .last_word (last_word),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .q_stat    (q_stat)
    );

    bvjs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .stat    (q_stat)
    );

    // The back end owns the output register, so empty is simply its
    // inverted valid flag.
    bvjs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .sim_count   (sim_count),
        .union_count (union_count),
        .jaccard_pct (jaccard_pct),
        .empty_union (empty_union)
    );

endmodule

>>> rtl/bvjs_port_checker.sv
// Port-level checker for the Jaccard similarity block, bound to the top level.
// Depends on bvjs_pkg and bit_vector_jaccard_similarity_assert.svh.
`include "bit_vector_jaccard_similarity_assert.svh"

module bvjs_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [bvjs_pkg::COUNT_W-1:0]  sim_count,
    input logic [bvjs_pkg::COUNT_W-1:0]  union_count,
    input logic [bvjs_pkg::PCT_W-1:0]    jaccard_pct,
    input logic                          empty_union
);
    import bvjs_pkg::*;

    // All result fields side by side, so a waiting result can be checked at once.
    logic [2*COUNT_W+PCT_W:0] result_bits;

    assign result_bits = {sim_count, union_count, jaccard_pct, empty_union};

    // The combined word is always a subset of the OR, so the totals are ordered.
    `BVJS_ASSERT_IMP(a_sim_le_union, clk, rst_n, !empty, sim_count <= union_count)

    `BVJS_ASSERT_IMP(a_pct_range, clk, rst_n, !empty, jaccard_pct <= PCT_W'(PCT_SCALE))

    // The flag matches a zero union, and then the percent is forced to zero.
    `BVJS_ASSERT_IMP(a_empty_union, clk, rst_n, !empty, empty_union == (union_count == '0))
    `BVJS_ASSERT_IMP(a_empty_pct, clk, rst_n, !empty && empty_union, jaccard_pct == '0)

    `BVJS_ASSERT_NXT(a_result_hold, clk, rst_n, !empty && !pop, !empty && $stable(result_bits))

endmodule

bind bit_vector_jaccard_similarity bvjs_port_checker u_port_checker (.*);
